>>> hw/rtl/natural_number_alu_assert.svh
// Assertion macros used by natural_number_alu.sv.
`ifndef NATURAL_NUMBER_ALU_ASSERT_SVH
`define NATURAL_NUMBER_ALU_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define NNA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define NNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/nna_pkg.sv
// ----------------------------------------------------------------------------
// nna_pkg
// Types and constants shared by the natural number ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nna_pkg;

  localparam int NatWidth = 63;
  localparam int DivSteps = NatWidth;

  typedef logic [NatWidth-1:0] nat_t;

  typedef enum logic [3:0] {
    OP_INC   = 4'd0,
    OP_ADD   = 4'd1,
    OP_MONUS = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_EQ    = 4'd6,
    OP_NE    = 4'd7,
    OP_LT    = 4'd8,
    OP_GT    = 4'd9,
    OP_LE    = 4'd10,
    OP_GE    = 4'd11
  } op_t;

  // One pipeline word: divider state plus the result of every other operation.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic div_zero;
    nat_t rem;
    nat_t dq;
    nat_t divisor;
    nat_t res;
    logic boolf;
    logic stat;
  } nna_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/nna_div_stage.sv
// ----------------------------------------------------------------------------
// nna_div_stage
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nna_div_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire nna_pkg::nna_stage_t stage_in,
  output nna_pkg::nna_stage_t      stage_out
);
  import nna_pkg::*;

  logic [NatWidth:0]   shifted;
  logic [NatWidth+1:0] diff;
  nna_stage_t          stage_next;

  always_comb begin
    shifted    = {stage_in.rem, stage_in.dq[NatWidth-1]};
    diff       = {1'b0, shifted} - {2'b00, stage_in.divisor};
    stage_next = stage_in;
    if (!diff[NatWidth+1]) begin
      stage_next.rem = diff[NatWidth-1:0];
      stage_next.dq  = {stage_in.dq[NatWidth-2:0], 1'b1};
    end else begin
      stage_next.rem = shifted[NatWidth-1:0];
      stage_next.dq  = {stage_in.dq[NatWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out <= stage_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/natural_number_alu.sv
// An accepted operand word is registered in stage 0, stage 1, each divider
// stage in turn and then the output register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register waits on result_stall.
// The divider sets the depth: 63 stages, one quotient bit each.
// Reset (synchronous, active high) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// natural_number_alu
// Pipelined ALU on 63-bit natural numbers: inc, add, monus, mul, div, mod and
// six comparisons, with overflow status for inc, add and mul.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_number_alu (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         operand_valid,
  output logic              operand_stall,
  input  wire logic [3:0]   operation,
  input  wire nna_pkg::nat_t left_operand,
  input  wire nna_pkg::nat_t right_operand,
  output logic              result_valid,
  input  wire logic         result_stall,
  output nna_pkg::nat_t     result_value,
  output logic              is_boolean,
  output logic              status
);
  import nna_pkg::*;

  `include "natural_number_alu_assert.svh"

  // Global advance: every stage moves unless the output word is stuck.
  logic en;
  assign en            = !(result_valid && result_stall);
  assign operand_stall = !en;

  // Stage 0: capture the operand word.
  logic s0_valid;
  op_t  s0_op;
  nat_t s0_a;
  nat_t s0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= operand_valid;
      s0_op    <= op_t'(operation);
      s0_a     <= left_operand;
      s0_b     <= right_operand;
    end
  end

  // Stage 1: cheap operations resolve here; the divider is seeded; the
  // multiplier forms its four partial products.
  logic [NatWidth:0] sum;
  nna_stage_t        s1_next;
  nna_stage_t        s1;

  always_comb begin
    sum              = {1'b0, s0_a} + {1'b0, s0_b};
    s1_next          = '0;
    s1_next.valid    = s0_valid;
    s1_next.op       = s0_op;
    s1_next.div_zero = (s0_b == '0);
    s1_next.dq       = s0_a;
    s1_next.divisor  = s0_b;
    unique case (s0_op)
      OP_INC: begin
        if (&s0_a) begin
          s1_next.stat = 1'b1;
        end else begin
          s1_next.res = s0_a + nat_t'(1);
        end
      end
      OP_ADD: begin
        if (sum[NatWidth]) begin
          s1_next.stat = 1'b1;
        end else begin
          s1_next.res = sum[NatWidth-1:0];
        end
      end
      OP_MONUS: s1_next.res = (s0_b >= s0_a) ? '0 : s0_a - s0_b;
      OP_DIV:   s1_next.res = '0;
      OP_MOD:   s1_next.res = s0_a;
      OP_EQ: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a == s0_b);
      end
      OP_NE: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a != s0_b);
      end
      OP_LT: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a < s0_b);
      end
      OP_GT: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a > s0_b);
      end
      OP_LE: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a <= s0_b);
      end
      OP_GE: begin
        s1_next.boolf = 1'b1;
        s1_next.res   = nat_t'(s0_a >= s0_b);
      end
      default: s1_next.res = '0;
    endcase
  end

  // Partial products: operands split into 32 low and 31 high bits.
  logic [63:0] pp_ll;
  logic [62:0] pp_lh;
  logic [62:0] pp_hl;
  logic [61:0] pp_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1    <= s1_next;
      pp_ll <= s0_a[31:0] * s0_b[31:0];
      pp_lh <= s0_a[31:0] * s0_b[62:32];
      pp_hl <= s0_a[62:32] * s0_b[31:0];
      pp_hh <= s0_a[62:32] * s0_b[62:32];
    end
  end

  // Sum the partial products into the full 126-bit product.
  logic [125:0] product;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= {62'd0, pp_ll}
               + {31'd0, pp_lh, 32'd0}
               + {31'd0, pp_hl, 32'd0}
               + {pp_hh, 64'd0};
    end
  end

  // Divider chain; the product merges into the word entering step one.
  nna_stage_t div_in  [DivSteps];
  nna_stage_t div_out [DivSteps];

  always_comb begin
    div_in[0] = s1;
  end

  always_comb begin
    div_in[1] = div_out[0];
    if (div_out[0].op == OP_MUL) begin
      if (product[125:NatWidth] != '0) begin
        div_in[1].res  = '0;
        div_in[1].stat = 1'b1;
      end else begin
        div_in[1].res  = product[NatWidth-1:0];
        div_in[1].stat = 1'b0;
      end
    end
  end

  for (genvar k = 2; k < DivSteps; k++) begin : g_link
    assign div_in[k] = div_out[k-1];
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    nna_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage_in  (div_in[k]),
      .stage_out (div_out[k])
    );
  end

  // Output register: pick quotient or remainder when a real division ran.
  nna_stage_t last;
  nat_t       result_value_next;

  assign last = div_out[DivSteps-1];

  always_comb begin
    result_value_next = last.res;
    if (!last.div_zero) begin
      if (last.op == OP_DIV) begin
        result_value_next = last.dq;
      end else if (last.op == OP_MOD) begin
        result_value_next = last.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.valid;
      result_value <= result_value_next;
      is_boolean   <= last.boolf;
      status       <= last.stat;
    end
  end

  `NNA_ASSERT_IMPL(a_ovf_not_bool, result_valid && status, !is_boolean && result_value == '0)
  `NNA_ASSERT_IMPL(a_bool_range, result_valid && is_boolean, result_value[NatWidth-1:1] == '0)
  `NNA_ASSERT_NEXT(a_hold_when_stuck, result_valid && result_stall, result_valid && $stable(result_value) && $stable(last.valid) && $stable(s0_valid))

endmodule

`default_nettype wire

>>> sim/natural_number_alu_checker.sv
// ----------------------------------------------------------------------------
// natural_number_alu_checker
// Watches both channels of the natural number ALU, predicts each result word
// from the accepted operand word and compares the two field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_number_alu_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          operand_valid,
  input  wire logic          operand_stall,
  input  wire logic [3:0]    operation,
  input  wire nna_pkg::nat_t left_operand,
  input  wire nna_pkg::nat_t right_operand,
  input  wire logic          result_valid,
  input  wire logic          result_stall,
  input  wire nna_pkg::nat_t result_value,
  input  wire logic          is_boolean,
  input  wire logic          status,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import nna_pkg::*;

  typedef struct packed {
    nat_t value;
    logic boolf;
    logic ovf;
  } alu_result_t;

  localparam nat_t NatMax = {NatWidth{1'b1}};

  alu_result_t expected_results[$];
  int          errors = 0;

  function automatic alu_result_t compute_result(logic [3:0] opc, nat_t a, nat_t b);
    alu_result_t r;
    logic [127:0] prod;
    r = '0;
    case (opc)
      OP_INC: begin
        if (a == NatMax) r.ovf = 1'b1;
        else r.value = a + 1'b1;
      end
      OP_ADD: begin
        if ({1'b0, a} + {1'b0, b} > {1'b0, NatMax}) r.ovf = 1'b1;
        else r.value = a + b;
      end
      OP_MONUS: r.value = (b >= a) ? '0 : a - b;
      OP_MUL: begin
        prod = 128'(a) * 128'(b);
        if (prod > 128'(NatMax)) r.ovf = 1'b1;
        else r.value = prod[NatWidth-1:0];
      end
      OP_DIV: r.value = (b == 0) ? '0 : a / b;
      OP_MOD: r.value = (b == 0) ? a : a % b;
      OP_EQ: begin r.value = nat_t'(a == b); r.boolf = 1'b1; end
      OP_NE: begin r.value = nat_t'(a != b); r.boolf = 1'b1; end
      OP_LT: begin r.value = nat_t'(a < b);  r.boolf = 1'b1; end
      OP_GT: begin r.value = nat_t'(a > b);  r.boolf = 1'b1; end
      OP_LE: begin r.value = nat_t'(a <= b); r.boolf = 1'b1; end
      OP_GE: begin r.value = nat_t'(a >= b); r.boolf = 1'b1; end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign fail_count    = errors;
  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst) begin
      if (operand_valid && !operand_stall)
        expected_results.push_back(compute_result(operation, left_operand, right_operand));
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_value !== exp_r.value) begin
            $error("result_value expected %0d actual %0d", exp_r.value, result_value);
            errors++;
          end
          if (is_boolean !== exp_r.boolf) begin
            $error("is_boolean expected %0d actual %0d", exp_r.boolf, is_boolean);
            errors++;
          end
          if (status !== exp_r.ovf) begin
            $error("status expected %0d actual %0d", exp_r.ovf, status);
            errors++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/natural_number_alu_tb.sv
// ----------------------------------------------------------------------------
// natural_number_alu_tb
// Drives directed and random operand words through the natural number ALU
// under several idle/stall mixes; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_number_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nna_pkg::*;

  localparam nat_t NatMax = {NatWidth{1'b1}};
  localparam int   DrainCycles = 200;  // well past the pipeline latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic operand_valid = 1'b0;
  logic operand_stall;
  logic [3:0] operation = '0;
  nat_t left_operand = '0;
  nat_t right_operand = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  nat_t result_value;
  logic is_boolean;
  logic status;
  int fail_count;
  int pending_count;

  // Idle and stall percentages of the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  natural_number_alu dut (
    .clk, .rst, .operand_valid, .operand_stall, .operation, .left_operand,
    .right_operand, .result_valid, .result_stall, .result_value, .is_boolean,
    .status
  );

  natural_number_alu_checker checker_i (
    .clk, .rst, .operand_valid, .operand_stall, .operation, .left_operand,
    .right_operand, .result_valid, .result_stall, .result_value, .is_boolean,
    .status, .fail_count, .pending_count
  );

  // Receiver side: redraw stall on every falling edge from the phase's mix.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Pick an operand biased toward the corners that matter for overflow and
  // the divider: zero, one, the maximum, small values and powers of two.
  function automatic nat_t pick_operand();
    nat_t v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = nat_t'(1);
      2: v = NatMax - nat_t'($urandom_range(2));
      3: v = nat_t'($urandom_range(100));
      4: v = nat_t'(1) << $urandom_range(NatWidth - 1);
      5: v = nat_t'($urandom) * nat_t'(2) + nat_t'($urandom_range(1)); // up to 2^33
      6: v = nat_t'($urandom_range(32'h7fffffff)); // fits products near the top
      default: v = nat_t'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  // Present one word from a falling edge and hold it until accepted; drop
  // valid only while idling.
  task automatic send_word(logic [3:0] opc, nat_t a, nat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_valid <= 1'b0;
      @(negedge clk);
    end
    operand_valid <= 1'b1;
    operation     <= opc;
    left_operand  <= a;
    right_operand <= b;
    @(posedge clk);
    while (operand_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [3:0] opc;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every opcode, unused opcodes, each corner case.
    send_word(OP_INC, NatMax, 0);          // increment overflow
    send_word(OP_INC, NatMax - 1, NatMax); // largest legal increment
    send_word(OP_ADD, NatMax, 1);          // sum overflow
    send_word(OP_ADD, NatMax - 5, 5);      // sum exactly at the max
    send_word(OP_MONUS, 3, 7);             // floors at zero
    send_word(OP_MONUS, 7, 7);
    send_word(OP_MONUS, NatMax, 1);
    send_word(OP_MUL, NatMax, 2);          // product overflow
    send_word(OP_MUL, NatMax, 1);
    send_word(OP_MUL, 0, NatMax);
    send_word(OP_MUL, 63'h4000_0000_0000_0000, 2);
    send_word(OP_DIV, NatMax, 0);          // divide by zero
    send_word(OP_DIV, NatMax, 3);
    send_word(OP_MOD, 12345, 0);           // modulo by zero keeps the left
    send_word(OP_MOD, NatMax, 10);
    send_word(OP_EQ, NatMax, NatMax);
    send_word(OP_NE, 0, NatMax);
    send_word(OP_LT, 0, NatMax);
    send_word(OP_GT, NatMax, 0);
    send_word(OP_LE, 5, 5);
    send_word(OP_GE, 4, 5);
    for (int k = 12; k < 16; k++) send_word(4'(k), NatMax, NatMax);

    // Random words, five phases of equal size; the first and last run
    // without idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 400; n++) begin
        opc = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                        : 4'($urandom_range(11));
        send_word(opc, pick_operand(), pick_operand());
      end
    end
    operand_valid <= 1'b0;

    // Drain: let outstanding results arrive, then wait DrainCycles more.
    recv_stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[natural_number_alu] OK");
    end else begin
      $display("[natural_number_alu] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("[natural_number_alu] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
